>>> design/sht_pkg.sv
// Types and constants shared across the session handle table.
`default_nettype none
package sht_pkg;

	localparam int HANDLE_W   = 32;
	localparam int SLOT_OUT_W = 3;
	// Widest slot number the table supports (up to 64 slots).
	localparam int SLOT_NUM_W = 6;

	localparam logic [HANDLE_W-1:0] HANDLE_BASE_RESET = 32'h0200_0000;
	localparam logic [HANDLE_W-1:0] SEQ_RESET         = 32'd1;
	localparam logic [HANDLE_W-1:0] FREE_HANDLE       = '0;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// Outcome of the parallel slot search.
	typedef struct packed {
		logic                  free_hit;
		logic [SLOT_NUM_W-1:0] free_idx;
		logic                  match_hit;
		logic [SLOT_NUM_W-1:0] match_idx;
	} slot_search_t;

	// Write command into the slot array.
	typedef struct packed {
		logic                  set;
		logic                  flush;
		logic                  clear_all;
		logic [SLOT_NUM_W-1:0] idx;
	} slot_upd_t;

endpackage
`default_nettype wire

>>> design/sht_if.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none
interface sht_req_if;
	logic                              valid;
	logic                              ready;
	sht_pkg::opcode_t                  opcode;
	logic [sht_pkg::HANDLE_W-1:0]      req_handle;

	modport source (output valid, output opcode, output req_handle, input ready);
	modport sink   (input valid, input opcode, input req_handle, output ready);
endinterface

interface sht_rsp_if;
	logic                              valid;
	logic                              ready;
	sht_pkg::status_t                  status;
	logic [sht_pkg::HANDLE_W-1:0]      handle_out;
	logic [sht_pkg::SLOT_OUT_W-1:0]    slot_index;

	modport source (output valid, output status, output handle_out, output slot_index,
		input ready);
	modport sink   (input valid, input status, input handle_out, input slot_index,
		output ready);
endinterface
`default_nettype wire

>>> design/session_handle_table_unit.sv
// Top level of the session handle table.
`default_nettype none
// Session handle table: SLOT_COUNT slots, each holding a 32-bit handle, zero
// meaning free. Requests (create, lookup, flush, clear) arrive on req, one
// response word per request leaves on rsp. A request is registered, then a
// single pass of SLOT_COUNT parallel compares plus a priority encoder picks the
// lowest free or matching slot, updates the table and fills the response
// register. Throughput is one request per clock unless rsp.ready stalls the
// response register. The back-to-back rate holds because the table and
// sequence counter are updated in the same cycle the response is formed, so
// the next request sees the new state. A response stalled on rsp.ready holds;
// the input register still accepts one more word behind it. New handles are
// handle_base | sequence; the sequence starts at 1, wraps at 2^32 and returns
// to 1 on clear. A request naming handle zero never matches. handle_base is
// written through cfg_we/cfg_wdata; the user must do so only while the block
// is idle, and the block itself does not enforce this.
module session_handle_table_unit #(
	parameter int SLOT_COUNT = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sht_pkg::HANDLE_W-1:0]  cfg_wdata,
	sht_req_if.sink                            req,
	sht_rsp_if.source                          rsp
);
	import sht_pkg::*;

	// Configuration
	logic [HANDLE_W-1:0] handle_base_q;
	logic [HANDLE_W-1:0] next_seq_q;

	// Stage 1: registered request
	logic                valid_s1;
	opcode_t             opcode_s1;
	logic [HANDLE_W-1:0] req_handle_s1;

	// Stage 2: response register
	logic                  valid_s2;
	status_t               status_s2;
	logic [HANDLE_W-1:0]   handle_s2;
	logic [SLOT_OUT_W-1:0] slot_s2;

	logic                  advance;
	slot_search_t          search;
	slot_upd_t             upd;
	logic [HANDLE_W-1:0]   new_handle;
	status_t               status_d;
	logic [HANDLE_W-1:0]   handle_d;
	logic [SLOT_OUT_W-1:0] slot_d;
	logic [HANDLE_W-1:0]   next_seq_d;

	// Stage 1 moves on when the response register is empty or being drained.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handle_base_q <= HANDLE_BASE_RESET;
		end else if (cfg_we) begin
			handle_base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1     <= req.opcode;
			req_handle_s1 <= req.req_handle;
		end
	end

	sht_slot_table #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (req_handle_s1),
		.upd       (upd),
		.set_value (new_handle),
		.search    (search)
	);

	assign new_handle = handle_base_q | next_seq_q;

	// Decode the request against the search result; table writes only fire
	// on the cycle the word leaves stage 1.
	always_comb begin
		status_d   = ST_OK;
		handle_d   = '0;
		slot_d     = '0;
		next_seq_d = next_seq_q;
		upd        = '0;
		unique case (opcode_s1)
			OP_CREATE: begin
				if (search.free_hit) begin
					handle_d   = new_handle;
					slot_d     = SLOT_OUT_W'(search.free_idx);
					next_seq_d = next_seq_q + HANDLE_W'(1);
					upd.set    = advance;
					upd.idx    = search.free_idx;
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_LOOKUP: begin
				if (search.match_hit) begin
					// the match equals the key, so the key is the stored handle
					handle_d = req_handle_s1;
					slot_d   = SLOT_OUT_W'(search.match_idx);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_FLUSH: begin
				if (search.match_hit) begin
					slot_d    = SLOT_OUT_W'(search.match_idx);
					upd.flush = advance;
					upd.idx   = search.match_idx;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				next_seq_d    = SEQ_RESET;
				upd.clear_all = advance;
			end
			default: begin
				status_d = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= SEQ_RESET;
		end else if (advance) begin
			next_seq_q <= next_seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_d;
			handle_s2 <= handle_d;
			slot_s2   <= slot_d;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.status     = status_s2;
	assign rsp.handle_out = handle_s2;
	assign rsp.slot_index = slot_s2;

endmodule
`default_nettype wire

>>> design/sht_slot_table.sv
// Slot array with parallel free/match search and single-port update.
`default_nettype none
module sht_slot_table #(
	parameter int SLOT_COUNT = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [sht_pkg::HANDLE_W-1:0]    key,
	input  wire sht_pkg::slot_upd_t              upd,
	input  wire logic [sht_pkg::HANDLE_W-1:0]    set_value,
	output sht_pkg::slot_search_t                search
);
	import sht_pkg::*;

	logic [HANDLE_W-1:0] slot_q [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) slot_q[i] <= FREE_HANDLE;
		end else begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (upd.clear_all) begin
					slot_q[i] <= FREE_HANDLE;
				end else if (upd.set && upd.idx == SLOT_NUM_W'(i)) begin
					slot_q[i] <= set_value;
				end else if (upd.flush && upd.idx == SLOT_NUM_W'(i)) begin
					slot_q[i] <= FREE_HANDLE;
				end
			end
		end
	end

	// Walk from the top down so the lowest-numbered hit wins.
	always_comb begin
		search = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (slot_q[i] == FREE_HANDLE) begin
				search.free_hit = 1'b1;
				search.free_idx = SLOT_NUM_W'(i);
			end
			if (key != FREE_HANDLE && slot_q[i] == key) begin
				search.match_hit = 1'b1;
				search.match_idx = SLOT_NUM_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/sht_checker.sv
// Port-level checks for the session handle table, bound to the top level.
`default_nettype none
module sht_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            req_ready,
	input wire logic                            rsp_valid,
	input wire logic                            rsp_ready,
	input wire logic [1:0]                      rsp_status,
	input wire logic [sht_pkg::HANDLE_W-1:0]    rsp_handle_out,
	input wire logic [sht_pkg::SLOT_OUT_W-1:0]  rsp_slot_index
);
	import sht_pkg::*;

	// No response word while in reset.
	a_quiet_in_reset: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response valid during reset");

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_handle_out) && $stable(rsp_slot_index))
		else $error("stalled response changed");

	// Failures carry no handle and slot zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_handle_out == '0 && rsp_slot_index == '0)
		else $error("failed response carries handle or slot");

	// With the response side empty the input side must be open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input blocked with empty response register");

endmodule

bind session_handle_table_unit sht_checker u_sht_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_handle_out (rsp.handle_out),
	.rsp_slot_index (rsp.slot_index)
);
`default_nettype wire
